// ===== sv/rbe_pkg.sv =====
// Shared constants, opcodes, state encoding and types for the rANS byte encoder.
package rbe_pkg;

    localparam int SCALE_BITS  = 12;
    localparam int NUM_SYMBOLS = 256;
    localparam int TABLE_AW    = $clog2(NUM_SYMBOLS);
    localparam int OP_W        = 2;
    localparam int SYM_W       = 8;
    localparam int FREQ_W      = 13;
    localparam int CUM_W       = 12;
    localparam int ENTRY_W     = FREQ_W + CUM_W;
    localparam int STATE_W     = 32;
    localparam int BYTE_W      = 8;
    localparam int IN_W        = ((OP_W + SYM_W + FREQ_W + CUM_W + 7) / 8) * 8;
    localparam int STATE_LOW_BIT = 23;
    // state >= ((2^23 >> SCALE_BITS) << 8) * freq  <=>  (state >> RENORM_SHIFT) >= freq
    localparam int RENORM_SHIFT  = STATE_LOW_BIT - SCALE_BITS + BYTE_W;
    localparam int BYTE_CNT_W    = 2;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_CYCLES    = STATE_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    localparam logic [STATE_W-1:0] STATE_INIT = STATE_W'(64'd1 << STATE_LOW_BIT);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RENORM,
        ST_DIV,
        ST_FLUSH
    } fsm_t;

    typedef struct packed {
        logic               done;
        logic [STATE_W-1:0] quotient;
        logic [FREQ_W-1:0]  remainder;
    } div_res_t;

endpackage

// ===== sv/rbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rbe_div.sv =====
// Radix-4 restoring divider: 32-bit dividend by 13-bit divisor, two bits per cycle.
module rbe_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rbe_pkg::STATE_W-1:0]   dividend,
    input  logic [rbe_pkg::FREQ_W-1:0]    divisor,
    output rbe_pkg::div_res_t             res
);
    import rbe_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [STATE_W-1:0]   quo_reg, quo_next;
    logic [FREQ_W-1:0]    rem_reg, rem_next;
    logic [FREQ_W-1:0]    dsr_reg, dsr_next;

    logic [STATE_W-1:0]   step_q;
    logic [FREQ_W-1:0]    step_r;
    logic [FREQ_W:0]      part;

    always_comb
    begin
        step_q = quo_reg;
        step_r = rem_reg;
        part   = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            part   = {step_r, step_q[STATE_W-1]};
            step_q = {step_q[STATE_W-2:0], 1'b0};
            if (part >= {1'b0, dsr_reg})
            begin
                part      = part - {1'b0, dsr_reg};
                step_q[0] = 1'b1;
            end
            step_r = part[FREQ_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = step_q;
            rem_next = step_r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dsr_reg))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ===== sv/rans_byte_encoder.sv =====
// Top level of the rANS byte encoder: control sequencer, coder state and output register.
//
//   channel  dir  fields (tdata low bit up)                        end marker
//   s_*      in   opcode[1:0] symbol[9:2] entry_freq[22:10]        -
//                 entry_cum[34:23], zero pad [39:35]
//   m_*      out  out_byte[7:0]                                    tlast = last_byte
//
// Flush emits the four coder state bytes, one per cycle unless m_tready stalls.
// Encode reads the table, emits the renormalization bytes (none up to four) one per cycle
// unless m_tready stalls, runs the radix-4 divider, then folds the result into the state.
// Encode of a zero-frequency symbol returns to idle after the table read, with no output.
// rst_n clears control and sets the coder state to 2^23; table contents are kept.
// A stalled m_tready holds the sequencer only when it has the next byte to hand off.
module rans_byte_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rbe_pkg::IN_W-1:0]   s_tdata,   // opcode, symbol, entry_freq, entry_cum
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rbe_pkg::BYTE_W-1:0] m_tdata,   // out_byte
    output logic                       m_tlast
);
    import rbe_pkg::*;

    fsm_t                  fsm_reg, fsm_next;
    logic [STATE_W-1:0]    coder_reg, coder_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    opcode_t               in_opcode;
    logic [SYM_W-1:0]      in_symbol;
    logic [FREQ_W-1:0]     in_freq;
    logic [CUM_W-1:0]      in_cum;
    logic                  accept;

    logic [ENTRY_W-1:0]    rd_entry;
    logic [FREQ_W-1:0]     rd_freq;
    logic [CUM_W-1:0]      rd_cum;
    logic                  ram_we, ram_re;

    logic [STATE_W-1:0]    coder_shift;
    logic                  renorm_hit, shift_hit, freq_zero;
    logic                  out_free, emit, emit_last;
    logic                  div_start;
    logic [STATE_W-1:0]    div_dividend;
    div_res_t              div_res;
    logic [STATE_W-1:0]    fold;

    assign in_opcode = opcode_t'(s_tdata[OP_W-1:0]);
    assign in_symbol = s_tdata[OP_W +: SYM_W];
    assign in_freq   = s_tdata[OP_W+SYM_W +: FREQ_W];
    assign in_cum    = s_tdata[OP_W+SYM_W+FREQ_W +: CUM_W];
    assign accept    = s_tvalid && s_tready;

    rbe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_symbol[TABLE_AW-1:0]),
        .wdata ({in_cum, in_freq}),
        .re    (ram_re),
        .raddr (in_symbol[TABLE_AW-1:0]),
        .rdata (rd_entry)
    );

    assign rd_freq = rd_entry[FREQ_W-1:0];
    assign rd_cum  = rd_entry[FREQ_W +: CUM_W];

    assign coder_shift = coder_reg >> BYTE_W;
    assign freq_zero   = (rd_freq == '0);
    assign renorm_hit  = (FREQ_W'(coder_reg >> RENORM_SHIFT) >= rd_freq);
    assign shift_hit   = (FREQ_W'(coder_shift >> RENORM_SHIFT) >= rd_freq);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign div_dividend = renorm_hit ? coder_shift : coder_reg;
    assign fold = (div_res.quotient << SCALE_BITS) + STATE_W'(rd_cum)
                + STATE_W'(div_res.remainder);

    rbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (rd_freq),
        .res      (div_res)
    );

    // next state
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_opcode)
                        OP_ENCODE:        fsm_next = ST_RENORM;
                        OP_FLUSH:         fsm_next = ST_FLUSH;
                        OP_LOAD, OP_NONE: fsm_next = ST_IDLE;
                    endcase
                end
            end
            ST_RENORM:
            begin
                priority if (freq_zero)
                    fsm_next = ST_IDLE;
                else if (!renorm_hit)
                    fsm_next = ST_DIV;
                else if (out_free && emit_last)
                    fsm_next = ST_DIV;
                else
                    fsm_next = ST_RENORM;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    fsm_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (out_free && (cnt_reg == '1))
                    fsm_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        emit      = 1'b0;
        emit_last = (cnt_reg == '1);
        div_start = 1'b0;
        unique case (fsm_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                ram_we   = accept && (in_opcode == OP_LOAD);
                ram_re   = accept && (in_opcode == OP_ENCODE);
            end
            ST_RENORM:
            begin
                emit_last = (cnt_reg == '1) || !shift_hit;
                emit      = !freq_zero && renorm_hit && out_free;
                div_start = !freq_zero && (!renorm_hit || (out_free && emit_last));
            end
            ST_DIV:
            begin
                div_start = 1'b0;
            end
            ST_FLUSH:
            begin
                emit = out_free;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        coder_next    = coder_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (accept)
            cnt_next = '0;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = coder_reg[BYTE_W-1:0];
            m_tlast_next  = emit_last;
            coder_next    = coder_shift;
            cnt_next      = cnt_reg + 1'b1;
        end
        if ((fsm_reg == ST_FLUSH) && emit && (cnt_reg == '1))
            coder_next = STATE_INIT;
        if ((fsm_reg == ST_DIV) && div_res.done)
            coder_next = fold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg      <= ST_IDLE;
            coder_reg    <= STATE_INIT;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg      <= fsm_next;
            coder_reg    <= coder_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef NO_ASSERTIONS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (fsm_reg == ST_DIV))
        else $error("divider finished outside division state");

    a_flush_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        ((fsm_reg == ST_IDLE) && ($past(fsm_reg) == ST_FLUSH)) |-> (coder_reg == STATE_INIT))
        else $error("coder state not reloaded after flush");

    a_encode_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_opcode == OP_ENCODE)) |=> ((fsm_reg == ST_RENORM) && (cnt_reg == '0)))
        else $error("encode transaction did not enter renormalization cleanly");
`endif

endmodule

// ===== bench/rans_byte_encoder_tb.sv =====
// Self-checking bench for the rANS byte encoder: directed table, then random phases.
`timescale 1ns / 100ps

module rans_byte_encoder_tb;
    import rbe_pkg::*;

    typedef struct packed {
        opcode_t            op;
        logic [SYM_W-1:0]   sym;
        logic [FREQ_W-1:0]  freq;
        logic [CUM_W-1:0]   cum;
        logic               typed;
        int unsigned        n;
        logic [STATE_W-1:0] bytes;
    } enc_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } out_byte_t;

    localparam int NDIR = 24;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;
    logic                m_tlast;

    logic [STATE_W-1:0]  model_state;
    logic [FREQ_W-1:0]   freq_tab [NUM_SYMBOLS];
    logic [CUM_W-1:0]    cum_tab [NUM_SYMBOLS];
    bit                  loaded [NUM_SYMBOLS];
    int                  sym_pool [$];
    out_byte_t           byte_q [$];
    out_byte_t           head;
    enc_item_t           dir_tab [NDIR];

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int err_cnt = 0;
    int n_load = 0;
    int n_enc = 0;
    int n_flush = 0;
    int n_nop = 0;
    int n_bytes = 0;

    rans_byte_encoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // advance the shadow coder by one transaction; bytes packed low byte first
    task automatic predict_bytes(input enc_item_t it, output int n,
                                 output logic [STATE_W-1:0] b);
        logic [FREQ_W-1:0] f;
        logic [63:0]       bound;
        n = 0;
        b = '0;
        case (it.op)
            OP_LOAD:
            begin
                freq_tab[it.sym] = it.freq;
                cum_tab[it.sym]  = it.cum;
            end
            OP_ENCODE:
            begin
                f = freq_tab[it.sym];
                if (f != 0)
                begin
                    bound = ((64'(STATE_INIT) >> SCALE_BITS) << BYTE_W) * 64'(f);
                    while (64'(model_state) >= bound && n < 4)
                    begin
                        b[n*8 +: 8] = model_state[7:0];
                        n++;
                        model_state = model_state >> 8;
                    end
                    model_state = ((model_state / STATE_W'(f)) << SCALE_BITS)
                                  + STATE_W'(cum_tab[it.sym])
                                  + (model_state % STATE_W'(f));
                end
            end
            OP_FLUSH:
            begin
                b = model_state;
                n = 4;
                model_state = STATE_INIT;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input enc_item_t it);
        int                 n;
        logic [STATE_W-1:0] b;
        out_byte_t          ob;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({it.cum, it.freq, it.sym, it.op});
        do
            @(posedge clk);
        while (!s_tready);
        predict_bytes(it, n, b);
        if (it.typed)
        begin
            n = int'(it.n);
            b = it.bytes;
        end
        for (int j = 0; j < n; j++)
        begin
            ob.value = b[j*8 +: 8];
            ob.last  = (j == n - 1);
            byte_q.push_back(ob);
        end
        case (it.op)
            OP_LOAD:
            begin
                n_load++;
                if (!loaded[it.sym])
                begin
                    loaded[it.sym] = 1'b1;
                    sym_pool.push_back(int'(it.sym));
                end
            end
            OP_ENCODE: n_enc++;
            OP_FLUSH:  n_flush++;
            default:   n_nop++;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            n_bytes++;
            if (byte_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                head = byte_q.pop_front();
                if (m_tdata !== head.value)
                begin
                    err_cnt++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, head.value, m_tdata);
                end
                if (m_tlast !== head.last)
                begin
                    err_cnt++;
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, head.last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t with %0d bytes outstanding", $time, byte_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        enc_item_t it;
        int        k;
        int        remaining;
        int        cumv;
        int        r;
        int        f;

        model_state = STATE_INIT;
        // typed rows: after reset, full-scale and unit frequency, zero frequency
        dir_tab = '{
            '{OP_FLUSH,  8'd0,   13'd0,    12'd0,    1'b1, 4, 32'h0080_0000},
            '{OP_NONE,   8'd255, 13'd4096, 12'd4095, 1'b1, 0, 32'h0},
            '{OP_LOAD,   8'd0,   13'd4096, 12'd0,    1'b1, 0, 32'h0},
            '{OP_ENCODE, 8'd0,   13'd0,    12'd0,    1'b1, 0, 32'h0},
            '{OP_FLUSH,  8'd0,   13'd0,    12'd0,    1'b1, 4, 32'h0080_0000},
            '{OP_LOAD,   8'd255, 13'd1,    12'd4095, 1'b1, 0, 32'h0},
            '{OP_ENCODE, 8'd255, 13'd0,    12'd0,    1'b1, 1, 32'h0},
            '{OP_FLUSH,  8'd0,   13'd0,    12'd0,    1'b1, 4, 32'h0800_0FFF},
            '{OP_LOAD,   8'd7,   13'd0,    12'd100,  1'b1, 0, 32'h0},
            '{OP_ENCODE, 8'd7,   13'd4096, 12'd4095, 1'b1, 0, 32'h0},
            '{OP_FLUSH,  8'd0,   13'd0,    12'd0,    1'b1, 4, 32'h0080_0000},
            '{OP_LOAD,   8'd128, 13'd2048, 12'd2048, 1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd128, 13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd255, 13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd255, 13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd255, 13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_LOAD,   8'd1,   13'd4096, 12'd4095, 1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd1,   13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd0,   13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_LOAD,   8'd0,   13'd1,    12'd0,    1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd0,   13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_ENCODE, 8'd0,   13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_FLUSH,  8'd0,   13'd0,    12'd0,    1'b0, 0, 32'h0},
            '{OP_NONE,   8'd0,   13'd0,    12'd0,    1'b1, 0, 32'h0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NDIR; i++)
            send_item(dir_tab[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 72; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 72; end
                default: begin snd_idle_pct = 13; rcv_stall_pct = 13; end
            endcase

            // well-formed table: contiguous cumulative starts covering the full scale
            k = $urandom_range(2, 12);
            remaining = 4096;
            cumv = 0;
            for (int i = 0; i < k; i++)
            begin
                f = (i == k - 1) ? remaining : $urandom_range(1, remaining - (k - 1 - i));
                it = '0;
                it.op   = OP_LOAD;
                it.sym  = SYM_W'($urandom_range(0, 255));
                it.freq = FREQ_W'(f);
                it.cum  = CUM_W'(cumv);
                send_item(it);
                cumv += f;
                remaining -= f;
            end

            for (int i = 0; i < 95; i++)
            begin
                it = '0;
                it.sym  = SYM_W'($urandom_range(0, 255));
                it.freq = FREQ_W'($urandom_range(0, 4096));
                it.cum  = CUM_W'($urandom_range(0, 4095));
                r = $urandom_range(0, 99);
                if (r < 12 || sym_pool.size() == 0)
                begin
                    it.op = OP_LOAD;
                    case ($urandom_range(0, 3))
                        0: it.freq = FREQ_W'($urandom_range(1, 15));
                        1: it.freq = 13'd1 << $urandom_range(0, 12);
                        2: it.freq = ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'd0;
                        default: ;
                    endcase
                end
                else if (r < 86)
                begin
                    it.op  = OP_ENCODE;
                    it.sym = SYM_W'(sym_pool[$urandom_range(0, sym_pool.size() - 1)]);
                end
                else if (r < 96)
                    it.op = OP_FLUSH;
                else
                    it.op = OP_NONE;
                send_item(it);
            end
        end

        it = '0;
        it.op = OP_FLUSH;
        send_item(it);
        @(posedge clk);
        s_tvalid <= 1'b0;

        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d loads, %0d encodes, %0d flushes, %0d unused opcodes",
                 n_load, n_enc, n_flush, n_nop);
        $display("checked %0d output bytes over four handshake pacing phases", n_bytes);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rbe_pkg.sv
sv/rbe_ram.sv
sv/rbe_div.sv
sv/rans_byte_encoder.sv
bench/rans_byte_encoder_tb.sv
